// ===== hw/rtl/dark_run_segment_extractor_top_macros.svh =====
// assertion macros shared by the dark run segment extractor
`ifndef DARK_RUN_SEGMENT_EXTRACTOR_TOP_MACROS_SVH
`define DARK_RUN_SEGMENT_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define DRSE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drse assertion failed");

// next-cycle implication
`define DRSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drse assertion failed");

`endif

// ===== hw/rtl/drse_pkg.sv =====
// types, constants and helper functions of the dark run segment extractor
`timescale 1ns / 1ps

package drse_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int COUNTER_LIMIT = 4096;

   localparam int COL_W  = 12;
   localparam int SIZE_W = 13;
   localparam int PITCH_W = 16;
   localparam int POS_W  = 28;
   localparam int PROD_W = 32;
   // doubled centre offset, -8189..8189
   localparam int OFF_W  = 15;

   localparam logic [SIZE_W-1:0] WIDTH_TOP  =
      SIZE_W'((MAX_WIDTH < COUNTER_LIMIT) ? MAX_WIDTH : COUNTER_LIMIT);
   localparam logic [SIZE_W-1:0] HEIGHT_TOP =
      SIZE_W'((MAX_HEIGHT < COUNTER_LIMIT) ? MAX_HEIGHT : COUNTER_LIMIT);

   localparam logic [7:0] DARK_LIMIT = 8'd128;
   localparam logic signed [PROD_W-1:0] POS_LIMIT = 32'sd134215680;

   // register indexes of the csr port
   typedef logic [1:0] csr_addr_type;
   localparam csr_addr_type CSR_IMAGE_WIDTH  = 2'd0;
   localparam csr_addr_type CSR_IMAGE_HEIGHT = 2'd1;
   localparam csr_addr_type CSR_PIXEL_PITCH  = 2'd2;

   localparam logic [SIZE_W-1:0]  RESET_WIDTH  = 13'd4096;
   localparam logic [SIZE_W-1:0]  RESET_HEIGHT = 13'd4096;
   localparam logic [PITCH_W-1:0] RESET_PITCH  = 16'd5014;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x_start_mm;
      logic signed [POS_W-1:0] x_end_mm;
      logic signed [POS_W-1:0] y_mm;
      logic [COL_W-1:0]        row_index;
      logic [COL_W-1:0]        col_start;
      logic [COL_W-1:0]        col_end;
   } rsp_type;

   // clamped image geometry and pitch
   typedef struct packed {
      logic [SIZE_W-1:0]  image_width;
      logic [SIZE_W-1:0]  image_height;
      logic [PITCH_W-1:0] pixel_pitch;
   } geom_type;

   // closed run handed from the tracker to the scaler
   typedef struct packed {
      logic [COL_W-1:0] row_index;
      logic [COL_W-1:0] col_start;
      logic [COL_W-1:0] col_end;
   } seg_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] top);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > top) begin
         r = top;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // floor halving, then saturation to the position range
   function automatic logic signed [POS_W-1:0] sat_half(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hv;
      logic signed [PROD_W-1:0] r;
      hv = v >>> 1;
      if (hv > POS_LIMIT) begin
         r = POS_LIMIT;
      end else if (hv < -POS_LIMIT) begin
         r = -POS_LIMIT;
      end else begin
         r = hv;
      end
      return r[POS_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/drse_tracker.sv =====
// raster position counters, run detection and the segment register
`timescale 1ns / 1ps

module drse_tracker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  drse_pkg::req_type  req_data,
   input  drse_pkg::geom_type geom,
   output logic               seg_valid,
   input  logic               seg_ready,
   output drse_pkg::seg_type  seg_data
);

   logic [drse_pkg::COL_W-1:0] col_ff, col_in;
   logic [drse_pkg::COL_W-1:0] row_ff, row_in;
   logic [drse_pkg::COL_W-1:0] run_start_ff, run_start_in;
   logic                       in_run_ff, in_run_in;
   logic                       seg_valid_ff, seg_valid_in;
   drse_pkg::seg_type          seg_ff, seg_in;

   logic                        accept;
   logic [drse_pkg::COL_W-1:0]  col, row, cs, ce;
   logic                        in_run, dark, last, row_last, emit;
   logic [drse_pkg::SIZE_W-1:0] wm1, hm1;

   assign req_ready = !seg_valid_ff || seg_ready;
   assign seg_valid = seg_valid_ff;
   assign seg_data  = seg_ff;

   always_comb begin
      accept   = req_valid && req_ready;
      col      = req_data.frame_start ? '0 : col_ff;
      row      = req_data.frame_start ? '0 : row_ff;
      in_run   = req_data.frame_start ? 1'b0 : in_run_ff;
      dark     = req_data.pixel_value < drse_pkg::DARK_LIMIT;
      wm1      = geom.image_width - drse_pkg::SIZE_W'(1);
      hm1      = geom.image_height - drse_pkg::SIZE_W'(1);
      last     = {1'b0, col} >= wm1;
      row_last = {1'b0, row} >= hm1;

      emit         = 1'b0;
      cs           = col;
      ce           = col;
      in_run_in    = in_run_ff;
      run_start_in = run_start_ff;
      col_in       = col_ff;
      row_in       = row_ff;

      if (dark && !in_run) begin
         if (last) begin
            emit = 1'b1;
         end else if (accept) begin
            run_start_in = col;
         end
      end else if (in_run && (!dark || last)) begin
         emit = 1'b1;
         cs   = run_start_ff;
         // a bright pixel ends the run on the column before it
         if (!dark) begin
            ce = (col == '0) ? '0 : col - drse_pkg::COL_W'(1);
         end
      end

      if (accept) begin
         in_run_in = (dark && !in_run && !last) ? 1'b1 : (emit ? 1'b0 : in_run);
         if (last) begin
            col_in = '0;
            row_in = row_last ? '0 : row + drse_pkg::COL_W'(1);
         end else begin
            col_in = col + drse_pkg::COL_W'(1);
            row_in = row;
         end
      end

      seg_in = seg_ff;
      if (accept) begin
         seg_valid_in = emit;
         seg_in       = '{row_index: row, col_start: cs, col_end: ce};
      end else if (seg_ready) begin
         seg_valid_in = 1'b0;
      end else begin
         seg_valid_in = seg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         in_run_ff    <= 1'b0;
         run_start_ff <= '0;
         seg_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         in_run_ff    <= in_run_in;
         run_start_ff <= run_start_in;
         seg_valid_ff <= seg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

endmodule

// ===== hw/rtl/drse_scaler.sv =====
// centre-relative offsets times pitch, then halving and saturation
`timescale 1ns / 1ps

module drse_scaler (
   input  logic               clock,
   input  logic               reset,
   input  logic               seg_valid,
   output logic               seg_ready,
   input  drse_pkg::seg_type  seg_data,
   input  drse_pkg::geom_type geom,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output drse_pkg::rsp_type  rsp_data
);

   logic signed [drse_pkg::PROD_W-1:0] px_start_ff, px_start_in;
   logic signed [drse_pkg::PROD_W-1:0] px_end_ff, px_end_in;
   logic signed [drse_pkg::PROD_W-1:0] py_ff, py_in;
   drse_pkg::seg_type                  meta_ff;
   logic                               mul_valid_ff, mul_valid_in;
   drse_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic                              mul_ready, seg_take, mul_take;
   logic signed [drse_pkg::OFF_W-1:0] dx_start, dx_end, dy;
   logic signed [16:0]                pitch_s;

   assign mul_ready = !rsp_valid_ff || rsp_ready;
   assign seg_ready = !mul_valid_ff || mul_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // multiply stage
   always_comb begin
      seg_take = seg_valid && seg_ready;
      pitch_s  = $signed({1'b0, geom.pixel_pitch});
      dx_start = $signed({2'b00, seg_data.col_start, 1'b0}) -
                 $signed({2'b00, geom.image_width});
      dx_end   = $signed({2'b00, seg_data.col_end, 1'b0}) -
                 $signed({2'b00, geom.image_width});
      dy       = $signed({2'b00, geom.image_height}) -
                 $signed({2'b00, seg_data.row_index, 1'b0});
      px_start_in = drse_pkg::PROD_W'(dx_start) * drse_pkg::PROD_W'(pitch_s);
      px_end_in   = drse_pkg::PROD_W'(dx_end) * drse_pkg::PROD_W'(pitch_s);
      py_in       = drse_pkg::PROD_W'(dy) * drse_pkg::PROD_W'(pitch_s);
      if (seg_ready) begin
         mul_valid_in = seg_valid;
      end else begin
         mul_valid_in = mul_valid_ff;
      end
   end

   // halve and saturate stage
   always_comb begin
      mul_take = mul_valid_ff && mul_ready;
      rsp_in   = rsp_ff;
      if (mul_take) begin
         rsp_in.x_start_mm = drse_pkg::sat_half(px_start_ff);
         rsp_in.x_end_mm   = drse_pkg::sat_half(px_end_ff);
         rsp_in.y_mm       = drse_pkg::sat_half(py_ff);
         rsp_in.row_index  = meta_ff.row_index;
         rsp_in.col_start  = meta_ff.col_start;
         rsp_in.col_end    = meta_ff.col_end;
      end
      if (mul_ready) begin
         rsp_valid_in = mul_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seg_take) begin
         px_start_ff <= px_start_in;
         px_end_ff   <= px_end_in;
         py_ff       <= py_in;
         meta_ff     <= seg_data;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// ===== hw/rtl/dark_run_segment_extractor_top.sv =====
// top level of the dark run segment extractor
`timescale 1ns / 1ps

// Dark run segment extractor. Takes one 8-bit grayscale pixel per req
// transaction in raster order and tracks column and row itself; frame_start
// on a pixel puts it at row 0, column 0 and drops any open run. A pixel below
// 128 is dark. A run of dark pixels closes at the first bright pixel or on
// the last column of the row, and each closed run gives one rsp transaction
// with its start and end columns, its row, and the matching positions from
// the image centre in units of 2^-16 mm (x right positive, y up positive),
// rounded toward minus infinity and saturated to +-134215680. A pixel that
// closes no run gives no rsp transaction. One pixel is taken every cycle as
// long as rsp keeps up; a segment passes through three register stages on its
// way to rsp: run tracker (loaded at the edge that takes its closing pixel),
// pitch multipliers, halving and saturation. Image width, height and pitch
// are written on the csr port (index 0, 1, 2); the user must write them only
// while the block is idle, which the block does not enforce; width and height
// are clamped to 1..4096. There is no clearing pass after reset.

`include "dark_run_segment_extractor_top_macros.svh"

module dark_run_segment_extractor_top (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  drse_pkg::req_type     req_data,
   // segment output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output drse_pkg::rsp_type     rsp_data,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  drse_pkg::csr_addr_type csr_index,
   input  logic [15:0]           csr_data
);

   // configuration registers, raw as written
   logic [drse_pkg::SIZE_W-1:0]  width_ff, width_in;
   logic [drse_pkg::SIZE_W-1:0]  height_ff, height_in;
   logic [drse_pkg::PITCH_W-1:0] pitch_ff, pitch_in;

   drse_pkg::geom_type geom;
   logic               seg_valid, seg_ready;
   drse_pkg::seg_type  seg_data;

   // writes never stall
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      pitch_in  = pitch_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            drse_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_data[drse_pkg::SIZE_W-1:0];
            drse_pkg::CSR_IMAGE_HEIGHT: height_in = csr_data[drse_pkg::SIZE_W-1:0];
            drse_pkg::CSR_PIXEL_PITCH:  pitch_in  = csr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= drse_pkg::RESET_WIDTH;
         height_ff <= drse_pkg::RESET_HEIGHT;
         pitch_ff  <= drse_pkg::RESET_PITCH;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         pitch_ff  <= pitch_in;
      end
   end

   // clamp the size to the counter range, one item of geometry for both units
   always_comb begin
      geom.image_width  = drse_pkg::clamp_size(width_ff, drse_pkg::WIDTH_TOP);
      geom.image_height = drse_pkg::clamp_size(height_ff, drse_pkg::HEIGHT_TOP);
      geom.pixel_pitch  = pitch_ff;
   end

   // column and row counters plus open-run state
   drse_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .geom      (geom),
      .seg_valid (seg_valid),
      .seg_ready (seg_ready),
      .seg_data  (seg_data)
   );

   // position scaling and the output register
   drse_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (seg_valid),
      .seg_ready (seg_ready),
      .seg_data  (seg_data),
      .geom      (geom),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // input only backs up when the segment register is full and blocked
   `DRSE_ASSERT_NOW(a_ready_backpressure, clock, reset, !req_ready, seg_valid && !seg_ready)

   // a bright first pixel of a frame closes nothing
   `DRSE_ASSERT_NEXT(a_frame_start_bright, clock, reset,
      req_valid && req_ready && req_data.frame_start &&
      (req_data.pixel_value >= drse_pkg::DARK_LIMIT), !seg_valid)

   // start never lies right of end, in columns and in position
   `DRSE_ASSERT_NOW(a_segment_order, clock, reset, rsp_valid,
      (rsp_data.col_start <= rsp_data.col_end) && (rsp_data.x_start_mm <= rsp_data.x_end_mm))

endmodule

// ===== test/tb_top.sv =====
// testbench for the dark run segment extractor: random raster pixels, run tracking prediction
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   // three register stages in the block, plus some margin
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   drse_pkg::req_type      req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   drse_pkg::rsp_type      rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   drse_pkg::csr_addr_type csr_index = drse_pkg::CSR_IMAGE_WIDTH;
   logic [15:0]            csr_data = '0;

   dark_run_segment_extractor_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // pixels waiting to be driven, segments waiting to come out
   drse_pkg::req_type pixel_queue[$];
   drse_pkg::rsp_type seg_due[$];
   int unsigned pixels_queued = 0;
   int unsigned pixels_taken  = 0;
   int unsigned errors        = 0;
   int unsigned cycle_count   = 0;

   // handshake flags sampled at the rising edge, used by the drivers at the falling edge
   bit req_fired = 1'b0;

   // idling control: percent chance per free cycle to start a burst
   int unsigned idle_pct = 0;
   bit          calm     = 1'b0;
   int unsigned req_gap  = 0;
   int unsigned rsp_gap  = 0;

   // shadow of the image geometry registers
   logic [12:0] cfg_width  = drse_pkg::RESET_WIDTH;
   logic [12:0] cfg_height = drse_pkg::RESET_HEIGHT;
   logic [15:0] cfg_pitch  = drse_pkg::RESET_PITCH;

   // shadow of the raster tracker
   int unsigned col_cnt   = 0;
   int unsigned row_cnt   = 0;
   bit          run_open  = 1'b0;
   int unsigned run_first = 0;

   // width or height after clamping into 1..top
   function automatic int unsigned clamp_dim(input logic [12:0] v, input logic [12:0] top);
      if (v == '0) begin
         return 1;
      end
      return (v > top) ? int'(top) : int'(v);
   endfunction

   // doubled offset from the centre times pitch, floor halved, saturated
   function automatic logic signed [27:0] pos_mm(input longint doubled);
      longint scaled;
      longint lim;
      lim    = longint'(drse_pkg::POS_LIMIT);
      scaled = (doubled * longint'(cfg_pitch)) >>> 1;
      if (scaled > lim) begin
         scaled = lim;
      end else if (scaled < -lim) begin
         scaled = -lim;
      end
      return scaled[27:0];
   endfunction

   // advance the raster position by one pixel and queue the segment it closes, if any
   task automatic track_pixel(input drse_pkg::req_type px);
      int unsigned       w;
      int unsigned       h;
      int unsigned       col;
      int unsigned       row;
      int unsigned       cs;
      int unsigned       ce;
      bit                dark;
      bit                last;
      bit                emit;
      drse_pkg::rsp_type seg;
      w    = clamp_dim(cfg_width, drse_pkg::WIDTH_TOP);
      h    = clamp_dim(cfg_height, drse_pkg::HEIGHT_TOP);
      cs   = 0;
      ce   = 0;
      emit = 1'b0;
      // frame start drops any open run and puts this pixel at the origin
      if (px.frame_start) begin
         col_cnt  = 0;
         row_cnt  = 0;
         run_open = 1'b0;
      end
      col  = col_cnt;
      row  = row_cnt;
      dark = px.pixel_value < drse_pkg::DARK_LIMIT;
      // a column past a shrunken width still counts as the last one
      last = col >= w - 1;
      if (dark && !run_open) begin
         if (last) begin
            // single dark pixel on the last column is a run of its own
            cs   = col;
            ce   = col;
            emit = 1'b1;
         end else begin
            run_first = col;
            run_open  = 1'b1;
         end
      end else if (run_open && (!dark || last)) begin
         cs       = run_first;
         ce       = dark ? col : ((col == 0) ? 0 : col - 1);
         emit     = 1'b1;
         run_open = 1'b0;
      end
      if (last) begin
         col_cnt = 0;
         // row past a shrunken height wraps to the top of the frame
         row_cnt = (row >= h - 1) ? 0 : ((row + 1) & 32'hFFF);
      end else begin
         col_cnt = (col + 1) & 32'hFFF;
      end
      if (emit) begin
         seg.x_start_mm = pos_mm(2 * longint'(cs) - longint'(w));
         seg.x_end_mm   = pos_mm(2 * longint'(ce) - longint'(w));
         seg.y_mm       = pos_mm(longint'(h) - 2 * longint'(row));
         seg.row_index  = 12'(row);
         seg.col_start  = 12'(cs);
         seg.col_end    = 12'(ce);
         seg_due = {seg_due, seg};
      end
   endtask

   // pixel driver: holds valid until the transaction is taken, inserts idle bursts
   always @(negedge clock) begin : pixel_drive
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_fired) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pixel_queue.size() > 0) begin
            if (!calm && $urandom_range(0, 99) < idle_pct) begin
               // start an idle burst instead of driving a pixel
               req_gap = $urandom_range(0, 15);
            end else begin
               req_data   <= pixel_queue.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   // segment sink: random stall bursts, independent of rsp_valid
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
         rsp_gap = $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: register writes, accepted pixels and delivered segments
   always @(posedge clock) begin : observe
      drse_pkg::rsp_type want;
      req_fired = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               drse_pkg::CSR_IMAGE_WIDTH:  cfg_width  = csr_data[12:0];
               drse_pkg::CSR_IMAGE_HEIGHT: cfg_height = csr_data[12:0];
               drse_pkg::CSR_PIXEL_PITCH:  cfg_pitch  = csr_data;
               default: ;
            endcase
         end
         // predict before checking so a same-edge segment would still line up
         if (req_valid && req_ready) begin
            req_fired = 1'b1;
            pixels_taken++;
            track_pixel(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (seg_due.size() == 0) begin
               $display("%0t: segment expected none actual row %0d cols %0d..%0d", $time,
                        rsp_data.row_index, rsp_data.col_start, rsp_data.col_end);
               errors++;
            end else begin
               want = seg_due.pop_front();
               if (rsp_data.x_start_mm !== want.x_start_mm) begin
                  $display("%0t: x_start_mm expected %0d actual %0d", $time,
                           $signed(want.x_start_mm), $signed(rsp_data.x_start_mm));
                  errors++;
               end
               if (rsp_data.x_end_mm !== want.x_end_mm) begin
                  $display("%0t: x_end_mm expected %0d actual %0d", $time,
                           $signed(want.x_end_mm), $signed(rsp_data.x_end_mm));
                  errors++;
               end
               if (rsp_data.y_mm !== want.y_mm) begin
                  $display("%0t: y_mm expected %0d actual %0d", $time,
                           $signed(want.y_mm), $signed(rsp_data.y_mm));
                  errors++;
               end
               if (rsp_data.row_index !== want.row_index) begin
                  $display("%0t: row_index expected %0d actual %0d", $time,
                           want.row_index, rsp_data.row_index);
                  errors++;
               end
               if (rsp_data.col_start !== want.col_start) begin
                  $display("%0t: col_start expected %0d actual %0d", $time,
                           want.col_start, rsp_data.col_start);
                  errors++;
               end
               if (rsp_data.col_end !== want.col_end) begin
                  $display("%0t: col_end expected %0d actual %0d", $time,
                           want.col_end, rsp_data.col_end);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic queue_pixel(input logic [7:0] pix, input logic fs);
      drse_pkg::req_type px;
      px.pixel_value = pix;
      px.frame_start = fs;
      pixel_queue = {pixel_queue, px};
      pixels_queued++;
   endtask

   // wait until every pixel is taken and every segment is out, then let the pipe drain
   task automatic settle();
      while (pixels_taken != pixels_queued || seg_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input drse_pkg::csr_addr_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one random phase: set geometry while idle, then stream pixels with random content
   task automatic run_phase(input logic [15:0] w, input logic [15:0] h, input logic [15:0] p,
                            input int n, input int dark_pct, input int fs_pct,
                            input bit pause_mid);
      bit dark;
      settle();
      write_reg(drse_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(drse_pkg::CSR_IMAGE_HEIGHT, h);
      write_reg(drse_pkg::CSR_PIXEL_PITCH, p);
      @(posedge clock);
      case ($urandom_range(0, 3))
         0: idle_pct = 0;
         1: idle_pct = 4;
         2: idle_pct = 12;
         default: idle_pct = 30;
      endcase
      for (int i = 0; i < n; i++) begin
         // sender holds off mid-frame until the pipe is empty
         if (pause_mid && i == n / 2) begin
            settle();
         end
         dark = $urandom_range(0, 99) < dark_pct;
         queue_pixel(dark ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255)),
                     $urandom_range(0, 99) < fs_pct);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset geometry, darkness threshold edges, frame start on a dark pixel
      idle_pct = 10;
      queue_pixel(8'd0, 1'b1);
      queue_pixel(8'd127, 1'b0);
      queue_pixel(8'd128, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd127, 1'b1);
      queue_pixel(8'd255, 1'b0);

      // 4x2 image at full pitch: lone dark pixel on the last column,
      // run closed by the last column, frame wrap into row 0
      settle();
      write_reg(drse_pkg::CSR_IMAGE_WIDTH, 16'd4);
      write_reg(drse_pkg::CSR_IMAGE_HEIGHT, 16'd2);
      write_reg(drse_pkg::CSR_PIXEL_PITCH, 16'hFFFF);
      @(posedge clock);
      queue_pixel(8'd200, 1'b1);
      queue_pixel(8'd128, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd10, 1'b0);
      queue_pixel(8'd20, 1'b0);
      queue_pixel(8'd30, 1'b0);
      queue_pixel(8'd40, 1'b0);
      queue_pixel(8'd127, 1'b0);
      queue_pixel(8'd255, 1'b0);

      // open a run on a wide row, then shrink the width under it
      settle();
      write_reg(drse_pkg::CSR_IMAGE_WIDTH, 16'd8);
      @(posedge clock);
      queue_pixel(8'd255, 1'b1);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd1, 1'b0);
      queue_pixel(8'd2, 1'b0);
      settle();
      write_reg(drse_pkg::CSR_IMAGE_WIDTH, 16'd3);
      @(posedge clock);
      queue_pixel(8'd3, 1'b0);
      queue_pixel(8'd128, 1'b0);

      // out-of-range sizes (clamped to 4096 and 1) with zero pitch
      run_phase(16'hFFFF, 16'd0, 16'd0, 40, 50, 3, 1'b1);
      // one pixel per row, deep into a tall frame
      run_phase(16'd1, 16'd4096, 16'hFFFF, 1560, 50, 0, 1'b1);
      // height collapses under a deep row: wrap to row 0
      run_phase(16'd1, 16'd0, 16'hFFFF, 10, 90, 0, 1'b0);
      // small random images
      run_phase(16'd2, 16'd1, 16'd1, 50, 50, 2, 1'b0);
      for (int k = 0; k < 3; k++) begin
         run_phase(16'($urandom_range(2, 12)), 16'($urandom_range(1, 6)),
                   16'($urandom_range(0, 65535)), 50, $urandom_range(30, 70), 2,
                   $urandom_range(0, 1));
      end
      // full size image at the reset pitch
      run_phase(16'd4096, 16'd4096, 16'd5014, 40, 50, 2, 1'b0);

      // last stretch without any idling
      settle();
      calm = 1'b1;
      run_phase(16'($urandom_range(2, 20)), 16'($urandom_range(1, 8)),
                16'($urandom_range(0, 65535)), 80, 50, 2, 1'b0);

      settle();
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
